@@ hdl/dmwc_pkg.sv @@
`default_nettype none
package dmwc_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 32;
	localparam int VICT_W = 10;

	// one access from the requester
	typedef struct packed {
		logic                     action;
		logic [ADDR_W-1:0]        address;
		logic signed [DATA_W-1:0] write_data;
	} req_t;

	// one result back to the requester
	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic                     hit;
		logic                     wrote_back;
		logic [VICT_W-1:0]        victim_page;
	} rsp_t;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WBACK,
		ST_FILL,
		ST_TAGW
	} back_state_t;

endpackage
`default_nettype wire

@@ hdl/dmwc_cdiv.sv @@
`default_nettype none
module dmwc_cdiv import dmwc_pkg::*; #(
	parameter int N  = 16,
	parameter int D  = 64,
	parameter int TW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  wire logic [N-1:0]  a,
	input  wire logic [TW-1:0] tin,
	output logic               vout,
	output logic [N-1:0]       q,
	output logic [N+10:0]      r,
	output logic [TW-1:0]      tout
);

	localparam int MW = N + 1;
	localparam int PW = N + MW;
	localparam int RW = N + 11;
	localparam logic [MW-1:0] M  = MW'((64'd1 << N) / D);
	localparam logic [RW-1:0] DV = RW'(D);

	logic          v_s1, v_s2, v_s3;
	logic [N-1:0]  a_s1;
	logic [TW-1:0] t_s1, t_s2, t_s3;
	logic [PW-1:0] prod, prod_s1;
	logic [N-1:0]  qe, q_s2, q_s3;
	logic [RW-1:0] rem, r_s2, r_s3;

	// estimate quotient by reciprocal, never above the true one
	assign prod = PW'(a) * PW'(M);
	assign qe   = prod_s1[N +: N];
	assign rem  = RW'(a_s1) - RW'(qe) * DV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload, correct the estimate by one step at the end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a;
			t_s1    <= tin;
			prod_s1 <= prod;
			q_s2    <= qe;
			r_s2    <= rem;
			t_s2    <= t_s1;
			t_s3    <= t_s2;
			if (r_s2 >= DV) begin
				q_s3 <= q_s2 + N'(1);
				r_s3 <= r_s2 - DV;
			end else begin
				q_s3 <= q_s2;
				r_s3 <= r_s2;
			end
		end
	end

	assign vout = v_s3;
	assign q    = q_s3;
	assign r    = r_s3;
	assign tout = t_s3;

endmodule
`default_nettype wire

@@ hdl/dmwc_front.sv @@
`default_nettype none
module dmwc_front import dmwc_pkg::*; #(
	parameter int PAGE_WORDS = 64,
	parameter int LINES      = 16,
	parameter int ADDR_BITS  = 16,
	parameter int ITEM_W     = 54
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	input  wire logic              clearing,
	input  wire logic              push_ready,
	output logic                   push_valid,
	output logic [ITEM_W-1:0]      push_data
);

	localparam int NPAGES = (2**ADDR_BITS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int PGW    = (NPAGES > 1) ? $clog2(NPAGES) : 1;
	localparam int OFW    = $clog2(PAGE_WORDS);
	localparam int LNW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int T1W    = 1 + DATA_W;
	localparam int T2W    = T1W + OFW + PGW;

	logic                 v1, v2;
	logic [ADDR_BITS-1:0] q1;
	logic [ADDR_BITS+10:0] r1;
	logic [T1W-1:0]       t1;
	logic [PGW-1:0]       q2;
	logic [PGW+10:0]      r2;
	logic [T2W-1:0]       t2;

	// stall the whole split pipeline while the queue is full; refuse requests while clearing
	assign req_ready = push_ready & ~clearing;

	// split address into page and offset
	dmwc_cdiv #(.N(ADDR_BITS), .D(PAGE_WORDS), .TW(T1W)) u_page (
		.clk(clk), .arst_n(arst_n), .en(push_ready),
		.vin(req_valid & ~clearing),
		.a(ADDR_BITS'(req.address)),
		.tin({req.action, req.write_data}),
		.vout(v1), .q(q1), .r(r1), .tout(t1)
	);

	// pick the line of the page
	dmwc_cdiv #(.N(PGW), .D(LINES), .TW(T2W)) u_line (
		.clk(clk), .arst_n(arst_n), .en(push_ready),
		.vin(v1),
		.a(q1[PGW-1:0]),
		.tin({t1, r1[OFW-1:0], q1[PGW-1:0]}),
		.vout(v2), .q(q2), .r(r2), .tout(t2)
	);

	assign push_valid = v2 & push_ready;
	assign push_data  = {t2, r2[LNW-1:0]};

endmodule
`default_nettype wire

@@ hdl/dmwc_fifo.sv @@
`default_nettype none
module dmwc_fifo import dmwc_pkg::*; #(
	parameter int W = 54
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              push_ready,
	input  wire logic         pop,
	output logic              pop_valid,
	output logic [W-1:0]      pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rp_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

@@ hdl/dmwc_back.sv @@
`default_nettype none
module dmwc_back import dmwc_pkg::*; #(
	parameter int PAGE_WORDS = 64,
	parameter int LINES      = 16,
	parameter int ADDR_BITS  = 16,
	parameter int ITEM_W     = 54
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	output logic                   clearing,
	input  wire logic              q_valid,
	input  wire logic [ITEM_W-1:0] q_data,
	output logic                   q_pop,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp
);

	localparam int NPAGES  = (2**ADDR_BITS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int PGW     = (NPAGES > 1) ? $clog2(NPAGES) : 1;
	localparam int OFW     = $clog2(PAGE_WORDS);
	localparam int LNW     = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int DEPTH_L = LINES * PAGE_WORDS;
	localparam int DAW     = $clog2(DEPTH_L);
	localparam int BACK_N  = 2**ADDR_BITS;
	localparam int CLR_N   = (BACK_N > LINES) ? BACK_N : LINES;
	localparam int CLW     = $clog2(CLR_N) + 1;
	localparam int BW      = ADDR_BITS + 11;
	localparam int TGW     = PGW + 2;
	localparam int CNW     = OFW + 1;

	// queue head fields
	logic                     h_act;
	logic [DATA_W-1:0]        h_wdata;
	logic [OFW-1:0]           h_off;
	logic [PGW-1:0]           h_page;
	logic [LNW-1:0]           h_line;

	assign {h_act, h_wdata, h_off, h_page, h_line} = q_data;

	back_state_t state_q, state_d;

	logic [CLW-1:0] clr_q;
	logic [CNW-1:0] cnt_q, cprev;
	logic           missed_q, wb_q, fok_q;
	logic [PGW-1:0] vict_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	// memories and their ports
	logic [DATA_W-1:0] line_mem [DEPTH_L];
	logic [DATA_W-1:0] back_mem [BACK_N];
	logic [TGW-1:0]    tag_mem  [LINES];

	logic              lr_en, lw_en, br_en, bw_en, tr_en, tw_en;
	logic [DAW-1:0]    lr_addr, lw_addr;
	logic [DATA_W-1:0] lw_data, bw_data, line_rd, back_rd;
	logic [ADDR_BITS-1:0] br_addr, bw_addr;
	logic [LNW-1:0]    tw_addr;
	logic [TGW-1:0]    tw_data, tag_rd;

	logic [DAW-1:0] lbase, slot;
	logic [BW-1:0]  wb_a, fill_a;
	logic           wb_inr, fill_inr;
	logic           t_valid, t_dirty, hit_w, out_free, produce, last;
	logic [PGW-1:0] t_page;

	assign {t_valid, t_dirty, t_page} = tag_rd;
	assign hit_w    = t_valid && (t_page == h_page);
	assign out_free = ~rsp_valid_q | rsp_ready;
	assign cprev    = cnt_q - CNW'(1);
	assign last     = (cnt_q == CNW'(PAGE_WORDS));

	assign lbase    = DAW'(h_line) * DAW'(PAGE_WORDS);
	assign slot     = lbase + DAW'(h_off);
	assign wb_a     = BW'(vict_q) * BW'(PAGE_WORDS) + BW'(cprev[OFW-1:0]);
	assign wb_inr   = (wb_a < BW'(BACK_N));
	assign fill_a   = BW'(h_page) * BW'(PAGE_WORDS) + BW'(cnt_q[OFW-1:0]);
	assign fill_inr = (fill_a < BW'(BACK_N));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == CLW'(CLR_N - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (q_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (hit_w) begin
					if (out_free) state_d = ST_IDLE;
				end else if (t_valid && t_dirty) begin
					state_d = ST_WBACK;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_WBACK:  if (last) state_d = ST_FILL;
			ST_FILL:   if (last) state_d = ST_TAGW;
			ST_TAGW:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls per state
	always_comb begin
		lr_en = 1'b0; lr_addr = slot;
		lw_en = 1'b0; lw_addr = slot; lw_data = h_wdata;
		br_en = 1'b0; br_addr = fill_a[ADDR_BITS-1:0];
		bw_en = 1'b0; bw_addr = wb_a[ADDR_BITS-1:0]; bw_data = line_rd;
		tr_en = 1'b0; tw_en = 1'b0; tw_addr = h_line; tw_data = {1'b1, 1'b1, h_page};
		produce = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				bw_en   = (clr_q < CLW'(BACK_N));
				bw_addr = clr_q[ADDR_BITS-1:0];
				bw_data = '0;
				tw_en   = (clr_q < CLW'(LINES));
				tw_addr = clr_q[LNW-1:0];
				tw_data = '0;
			end
			ST_IDLE: begin
				lr_en = q_valid;
				tr_en = q_valid;
			end
			ST_LOOKUP: begin
				produce = hit_w & out_free;
				lw_en   = produce & (h_act == ACT_WRITE);
				tw_en   = produce & (h_act == ACT_WRITE);
			end
			ST_WBACK: begin
				lr_en   = ~last;
				lr_addr = lbase + DAW'(cnt_q[OFW-1:0]);
				bw_en   = (cnt_q != '0) & wb_inr;
			end
			ST_FILL: begin
				br_en   = ~last & fill_inr;
				lw_en   = (cnt_q != '0);
				lw_addr = lbase + DAW'(cprev[OFW-1:0]);
				lw_data = fok_q ? back_rd : '0;
			end
			ST_TAGW: begin
				tw_en   = 1'b1;
				tw_data = {1'b1, 1'b0, h_page};
			end
			default: ;
		endcase
	end

	assign q_pop    = produce;
	assign clearing = (state_q == ST_CLEAR);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			missed_q    <= 1'b0;
			wb_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CLW'(1);
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_WBACK || state_q == ST_FILL) begin
				cnt_q <= cnt_q + CNW'(1);
			end
			if (state_q == ST_LOOKUP && !hit_w) begin
				missed_q <= 1'b1;
				wb_q     <= t_valid & t_dirty;
			end else if (produce) begin
				missed_q <= 1'b0;
				wb_q     <= 1'b0;
			end
			if (produce) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// result payload and victim page
	always_ff @(posedge clk) begin
		fok_q <= fill_inr;
		if (state_q == ST_LOOKUP && !hit_w) vict_q <= t_page;
		if (produce) begin
			rsp_q.read_data   <= (h_act == ACT_WRITE) ? '0 : line_rd;
			rsp_q.hit         <= ~missed_q;
			rsp_q.wrote_back  <= wb_q;
			rsp_q.victim_page <= wb_q ? VICT_W'(vict_q) : '0;
		end
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (lw_en) line_mem[lw_addr] <= lw_data;
		if (lr_en) line_rd <= line_mem[lr_addr];
	end

	always_ff @(posedge clk) begin
		if (bw_en) back_mem[bw_addr] <= bw_data;
		if (br_en) back_rd <= back_mem[br_addr];
	end

	always_ff @(posedge clk) begin
		if (tw_en) tag_mem[tw_addr] <= tw_data;
		if (tr_en) tag_rd <= tag_mem[h_line];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a lookup repeated after a fill must hit
	a_refill_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && missed_q) |-> hit_w)
		else $error("lookup after fill missed");

	// write-back flag only follows a miss
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		wb_q |-> missed_q)
		else $error("write-back without miss");

	// pop only a present head, never while a result would be lost
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (!rsp_valid_q || rsp_ready)))
		else $error("bad pop");

	// tag update after fill returns to idle
	a_tagw_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAGW) |=> (state_q == ST_IDLE))
		else $error("tag write not followed by idle");

endmodule
`default_nettype wire

@@ hdl/direct_mapped_writeback_cache.sv @@
// Direct-mapped write-back cache over a word-addressed backing memory.
// Request channel req_valid/req_ready/req carries one access: a read or a
// write of one word at a flat address. Response channel rsp_valid/rsp_ready/
// rsp returns one result per access, in order: read data (zero on a write),
// hit, a write-back flag and the victim page.
// A front pipeline splits the address into page, offset and line and
// feeds a two-entry queue; the back sequencer serves the head.
// A hit passes the idle state (tag and data read), then the lookup state
// (result, which waits while the output register is full); the next access
// starts only after that, limited by the registered tag read. A miss adds
// the failed tag read and lookup, a fill of the line from backing memory and
// one tag update. A dirty victim adds copy-back, one word per cycle over the
// line memory read port.
// After reset the backing memory and tag store are cleared, one entry per
// cycle, up to max(2**ADDR_BITS, LINES) entries; req_ready stays low meanwhile.
// When the receiver stalls, the result waits in the output register, the
// queue fills, and then req_ready drops and the front pipeline holds.
`default_nettype none
module direct_mapped_writeback_cache import dmwc_pkg::*; #(
	parameter int PAGE_WORDS = 64,
	parameter int LINES      = 16,
	parameter int ADDR_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int NPAGES = (2**ADDR_BITS + PAGE_WORDS - 1) / PAGE_WORDS;
	localparam int PGW    = (NPAGES > 1) ? $clog2(NPAGES) : 1;
	localparam int OFW    = $clog2(PAGE_WORDS);
	localparam int LNW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int ITEM_W = 1 + DATA_W + OFW + PGW + LNW;

	logic              clearing, push, push_ready, pop, pop_valid;
	logic [ITEM_W-1:0] push_data, pop_data;

	dmwc_front #(
		.PAGE_WORDS(PAGE_WORDS), .LINES(LINES), .ADDR_BITS(ADDR_BITS), .ITEM_W(ITEM_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.clearing(clearing),
		.push_ready(push_ready), .push_valid(push), .push_data(push_data)
	);

	dmwc_fifo #(.W(ITEM_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .push_ready(push_ready),
		.pop(pop), .pop_valid(pop_valid), .pop_data(pop_data)
	);

	dmwc_back #(
		.PAGE_WORDS(PAGE_WORDS), .LINES(LINES), .ADDR_BITS(ADDR_BITS), .ITEM_W(ITEM_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.clearing(clearing),
		.q_valid(pop_valid), .q_data(pop_data), .q_pop(pop),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

endmodule
`default_nettype wire

@@ verif/direct_mapped_writeback_cache_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module direct_mapped_writeback_cache_tb;
	import dmwc_pkg::*;

	localparam int PAGE_WORDS = 64;
	localparam int LINES      = 16;
	localparam int ADDR_BITS  = 16;
	localparam int NUM_RANDOM = 480;

	// shadow of the cache and backing memory; computes the expected result of each access
	class cache_scoreboard;
		bit            line_valid [LINES];
		bit [9:0]      line_page  [LINES];
		bit            line_dirty [LINES];
		bit [31:0]     line_words [LINES*PAGE_WORDS];
		bit [31:0]     backing    [int];
		rsp_t          pending    [$];
		int            errors;
		int            checked;
		int            hits;
		int            writebacks;

		function bit [31:0] mem_read(int a);
			if (backing.exists(a))
				return backing[a];
			return 32'd0;
		endfunction

		// compute the result of one accepted access and queue it
		function void note_access(req_t r);
			int   page, offs, ln, base, i;
			rsp_t e;
			page = int'(r.address) / PAGE_WORDS;
			offs = int'(r.address) % PAGE_WORDS;
			ln   = page % LINES;
			e = '0;
			e.hit = line_valid[ln] && line_page[ln] == page[9:0];
			if (!e.hit) begin
				if (line_valid[ln] && line_dirty[ln]) begin
					base = int'(line_page[ln]) * PAGE_WORDS;
					for (i = 0; i < PAGE_WORDS; i++)
						backing[base + i] = line_words[ln*PAGE_WORDS + i];
					e.wrote_back  = 1'b1;
					e.victim_page = line_page[ln];
				end
				base = page * PAGE_WORDS;
				for (i = 0; i < PAGE_WORDS; i++)
					line_words[ln*PAGE_WORDS + i] = mem_read(base + i);
				line_valid[ln] = 1'b1;
				line_page[ln]  = page[9:0];
				line_dirty[ln] = 1'b0;
			end
			if (r.action == ACT_WRITE) begin
				line_words[ln*PAGE_WORDS + offs] = r.write_data;
				line_dirty[ln] = 1'b1;
			end else begin
				e.read_data = line_words[ln*PAGE_WORDS + offs];
			end
			pending.push_back(e);
		endfunction

		// compare one result with the oldest expectation
		task check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report_mismatch("result with none expected", 32'd0, got.read_data);
				return;
			end
			e = pending.pop_front();
			checked++;
			hits       += e.hit;
			writebacks += e.wrote_back;
			if (got.read_data !== e.read_data)
				report_mismatch("read_data", e.read_data, got.read_data);
			if (got.hit !== e.hit)
				report_mismatch("hit", 32'(e.hit), 32'(got.hit));
			if (got.wrote_back !== e.wrote_back)
				report_mismatch("wrote_back", 32'(e.wrote_back), 32'(got.wrote_back));
			if (got.victim_page !== e.victim_page)
				report_mismatch("victim_page", 32'(e.victim_page), 32'(got.victim_page));
		endtask

		task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
			errors++;
			$display("mismatch %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	cache_scoreboard sb;
	bit calm;       // no idling on either side
	bit hold_off;   // receiver holds off for a long stretch

	direct_mapped_writeback_cache #(
		.PAGE_WORDS(PAGE_WORDS),
		.LINES(LINES),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive one access and hold it until the transfer
	task automatic send_access(logic act, logic [15:0] addr, logic [31:0] data);
		req_t r;
		while (!calm && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		r.action     = act;
		r.address    = addr;
		r.write_data = data;
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_access(r);
	endtask

	// pick an address mostly from a few pages that collide on a handful of lines, sometimes from any page
	function automatic logic [15:0] pick_address();
		int pg;
		case ($urandom_range(3))
			0: pg = $urandom_range(3);
			1: pg = $urandom_range(3) * LINES + $urandom_range(1);
			2: pg = $urandom_range(1023);
			default: pg = ($urandom_range(7) * LINES + 5) % 1024;
		endcase
		return 16'(pg * PAGE_WORDS + $urandom_range(PAGE_WORDS - 1));
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (hold_off)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// long hold-off counted in cycles while the sender keeps offering
	initial begin
		hold_off = 1'b0;
		wait (sb != null && sb.checked >= 60);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int i, drain;
		logic [31:0] d;
		sb = new();
		calm      = 1'b0;
		arst_n    = 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// directed: unwritten reads, extremes, dirty eviction, same-line conflicts
		send_access(ACT_READ, 16'h0000, 32'hFFFF_FFFF);
		send_access(ACT_READ, 16'hFFFF, 32'h0);
		send_access(ACT_WRITE, 16'h0000, 32'h8000_0000);
		send_access(ACT_WRITE, 16'h003F, 32'h7FFF_FFFF);
		send_access(ACT_READ, 16'h0000, 32'h0);
		send_access(ACT_READ, 16'h003F, 32'h0);
		send_access(ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
		send_access(ACT_WRITE, 16'h0400, 32'h1234_5678);
		send_access(ACT_READ, 16'h0000, 32'h0);
		send_access(ACT_READ, 16'h0400, 32'h0);
		send_access(ACT_WRITE, 16'h0800, 32'hAAAA_5555);
		send_access(ACT_READ, 16'hFFC0, 32'h0);
		send_access(ACT_WRITE, 16'h0BFF, 32'h5555_AAAA);
		send_access(ACT_READ, 16'h0400, 32'h0);
		send_access(ACT_READ, 16'h0BFF, 32'h0);
		send_access(ACT_READ, 16'hFFFF, 32'h0);

		// random: mostly conflicting pages, calm stretch in the middle
		for (i = 0; i < NUM_RANDOM; i++) begin
			calm = (i >= 150 && i < 250);
			d = $urandom();
			send_access($urandom_range(1) ? ACT_WRITE : ACT_READ, pick_address(), d);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		// drain outstanding results
		while (sb.pending.size() != 0)
			@(posedge clk);
		for (drain = 0; drain < 200; drain++)
			@(posedge clk);

		$display("covered %0d accesses: %0d hits, %0d dirty write-backs",
			sb.checked, sb.hits, sb.writebacks);
		$display("includes a long receiver stall and conflicting pages per line");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit: clear pass, misses with write-back, stalls, all several times over
	initial begin
		#20_000_000;
		$display("timeout");
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
